// File: design/phacc_pkg.sv
// Shared types and constants for the pixel hit accumulator.
// Item and command structs, command kinds, back-end states, color blend.
// No dependencies.
package phacc_pkg;

  // Opcodes of the input word
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [8:0]  GRID_SIZE_RESET = 9'd256;
  // Color of a cell with no hits
  localparam logic [31:0] COLOR_EMPTY     = 32'h0000_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [31:0]        hit_color;
    logic [7:0]         transform_id;
    logic [15:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] cell_count;
    logic [31:0] cell_color;
    logic [7:0]  cell_transform;
    logic [15:0] max_count;
    logic [16:0] list_length;
  } out_item_t;

  // Classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_CLEAR,
    CMD_READ,
    CMD_SKIP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] color;
    logic [7:0]  tid;
    logic [15:0] ridx;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADD_LIST,
    BK_ADD_FIN,
    BK_RD_CELL,
    BK_RD_FIN
  } back_state_t;

  // Per-channel average of two packed 8-bit colors, truncated
  function automatic logic [31:0] blend_color(input logic [31:0] a, input logic [31:0] b);
    logic [8:0]  sum;
    logic [31:0] res;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      sum = {1'b0, a[ch*8 +: 8]} + {1'b0, b[ch*8 +: 8]};
      res[ch*8 +: 8] = sum[8:1];
    end
    return res;
  endfunction

endpackage

// File: design/phacc_queue.sv
// Small command FIFO between the front classifier and the back executor.
// Uses phacc_pkg::cmd_t.
module phacc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  phacc_pkg::cmd_t   push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output phacc_pkg::cmd_t   pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  phacc_pkg::cmd_t  slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != FW'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer wrap and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/phacc_front.sv
// Front end: accepts input words, bounds-checks hits against the active grid
// and turns each word into a command for the queue. Uses phacc_pkg.
module phacc_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  phacc_pkg::in_item_t   in_data,
  input  logic [8:0]            grid_width,
  input  logic [8:0]            grid_height,
  output logic                  push_valid,
  input  logic                  push_ready,
  output phacc_pkg::cmd_t       push_cmd
);

  logic [15:0] x_u, y_u;
  logic        x_in, y_in, in_grid;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  // Inside test: non-negative and below both the register and the grid limit
  assign x_u     = in_data.x_coord;
  assign y_u     = in_data.y_coord;
  assign x_in    = !x_u[15] && (x_u < {7'd0, grid_width})  && (x_u < 16'(MAX_WIDTH));
  assign y_in    = !y_u[15] && (y_u < {7'd0, grid_height}) && (y_u < 16'(MAX_HEIGHT));
  assign in_grid = x_in && y_in;

  // Classify
  always_comb begin
    push_cmd.x     = x_u;
    push_cmd.y     = y_u;
    push_cmd.color = in_data.hit_color;
    push_cmd.tid   = in_data.transform_id;
    push_cmd.ridx  = in_data.read_index;
    case (in_data.opcode)
      phacc_pkg::OP_ADD:   push_cmd.kind = in_grid ? phacc_pkg::CMD_ADD : phacc_pkg::CMD_SKIP;
      phacc_pkg::OP_CLEAR: push_cmd.kind = phacc_pkg::CMD_CLEAR;
      phacc_pkg::OP_READ:  push_cmd.kind = phacc_pkg::CMD_READ;
      default:             push_cmd.kind = phacc_pkg::CMD_SKIP;
    endcase
  end

endmodule

// File: design/phacc_back.sv
// Back end: executes commands against the cell and touched-list memories
// and drives the result register. Uses phacc_pkg.
// A cell is live only when its stored list position points back at it
// below the list length, so clear and reset just zero the length.
module phacc_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  phacc_pkg::cmd_t       pop_cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output phacc_pkg::out_item_t  out_data
);

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int AW        = XW + YW;
  localparam int NUM_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int CMPW      = AW + 1;
  localparam int RW        = (CMPW > 16) ? CMPW : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [31:0]           color;
    logic [7:0]            tid;
    logic [AW-1:0]         pos;
  } cell_t;

  // Memories
  cell_t          cell_mem [0:(1 << AW) - 1];
  logic [AW-1:0]  list_mem [0:NUM_CELLS - 1];

  cell_t          cell_q;
  logic [AW-1:0]  list_q;
  logic           cell_re, cell_we, list_re, list_we;
  logic [AW-1:0]  cell_raddr, cell_waddr, list_raddr, list_waddr, list_wdata;
  cell_t          cell_wdata;

  // Control and status
  phacc_pkg::back_state_t state_r, state_nxt;
  phacc_pkg::cmd_t        cmd_r;
  logic                   load_cmd;
  logic [CMPW-1:0]        count_r, count_nxt;
  logic [COUNT_BITS-1:0]  max_r, max_nxt;
  logic                   out_valid_r, out_load, slot_free;
  phacc_pkg::out_item_t   out_data_r, out_data_nxt;

  // Datapath
  logic [AW-1:0]          pop_idx, cmd_idx;
  logic [RW-1:0]          ridx_w, count_rw;
  logic                   ridx_ok;
  logic [CMPW-1:0]        pos_w;
  logic                   hit_live;
  logic [COUNT_BITS-1:0]  prev_cnt, new_cnt;
  logic [31:0]            prev_col, new_col;

  // Result fields
  logic                   res_acc;
  logic [XW-1:0]          res_x;
  logic [YW-1:0]          res_y;
  logic [COUNT_BITS-1:0]  res_cnt;
  logic [31:0]            res_col;
  logic [7:0]             res_tid;
  logic [15:0]            res_x_w, res_y_w;
  logic [31:0]            res_cnt_w, max_w, len_w;

  assign slot_free = !out_valid_r || out_ready;
  assign pop_idx   = {pop_cmd.y[YW-1:0], pop_cmd.x[XW-1:0]};
  assign cmd_idx   = {cmd_r.y[YW-1:0], cmd_r.x[XW-1:0]};
  assign ridx_w    = RW'(pop_cmd.ridx);
  assign count_rw  = RW'(count_r);
  assign ridx_ok   = ridx_w < count_rw;
  assign pos_w     = CMPW'(cell_q.pos);
  assign hit_live  = (pos_w < count_r) && (list_q == cmd_idx);

  // Old cell contents; a cell not live reads as empty
  always_comb begin
    if (hit_live) begin
      prev_cnt = cell_q.count;
      prev_col = cell_q.color;
    end else begin
      prev_cnt = '0;
      prev_col = phacc_pkg::COLOR_EMPTY;
    end
  end

  assign new_cnt = (prev_cnt == COUNT_MAX) ? prev_cnt : prev_cnt + COUNT_BITS'(1);
  assign new_col = phacc_pkg::blend_color(prev_col, cmd_r.color);

  // Sequencer: next state, memory strobes and result
  always_comb begin
    state_nxt  = state_r;
    pop_ready  = 1'b0;
    load_cmd   = 1'b0;
    cell_re    = 1'b0;
    cell_raddr = '0;
    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = '0;
    list_re    = 1'b0;
    list_raddr = '0;
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = '0;
    count_nxt  = count_r;
    max_nxt    = max_r;
    out_load   = 1'b0;
    res_acc    = 1'b0;
    res_x      = '0;
    res_y      = '0;
    res_cnt    = '0;
    res_col    = '0;
    res_tid    = '0;
    case (state_r)
      phacc_pkg::BK_IDLE: begin
        pop_ready = slot_free;
        if (pop_valid && slot_free) begin
          load_cmd = 1'b1;
          case (pop_cmd.kind)
            phacc_pkg::CMD_ADD: begin
              cell_re    = 1'b1;
              cell_raddr = pop_idx;
              state_nxt  = phacc_pkg::BK_ADD_LIST;
            end
            phacc_pkg::CMD_READ: begin
              if (ridx_ok) begin
                list_re    = 1'b1;
                list_raddr = ridx_w[AW-1:0];
                state_nxt  = phacc_pkg::BK_RD_CELL;
              end else begin
                out_load = 1'b1;
              end
            end
            phacc_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              max_nxt   = '0;
              out_load  = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      // Fetch the list entry the cell claims to own
      phacc_pkg::BK_ADD_LIST: begin
        list_re    = 1'b1;
        list_raddr = cell_q.pos;
        state_nxt  = phacc_pkg::BK_ADD_FIN;
      end
      // Write back the cell, append on first hit
      phacc_pkg::BK_ADD_FIN: begin
        if (slot_free) begin
          cell_we          = 1'b1;
          cell_waddr       = cmd_idx;
          cell_wdata.count = new_cnt;
          cell_wdata.color = new_col;
          cell_wdata.tid   = cmd_r.tid;
          if (hit_live) begin
            cell_wdata.pos = cell_q.pos;
          end else begin
            cell_wdata.pos = count_r[AW-1:0];
            list_we        = 1'b1;
            list_waddr     = count_r[AW-1:0];
            list_wdata     = cmd_idx;
            count_nxt      = count_r + CMPW'(1);
          end
          if (new_cnt > max_r) begin
            max_nxt = new_cnt;
          end
          res_acc   = 1'b1;
          out_load  = 1'b1;
          state_nxt = phacc_pkg::BK_IDLE;
        end
      end
      phacc_pkg::BK_RD_CELL: begin
        cell_re    = 1'b1;
        cell_raddr = list_q;
        state_nxt  = phacc_pkg::BK_RD_FIN;
      end
      phacc_pkg::BK_RD_FIN: begin
        if (slot_free) begin
          res_acc   = 1'b1;
          res_x     = list_q[XW-1:0];
          res_y     = list_q[AW-1:XW];
          res_cnt   = cell_q.count;
          res_col   = cell_q.color;
          res_tid   = cell_q.tid;
          out_load  = 1'b1;
          state_nxt = phacc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = phacc_pkg::BK_IDLE;
      end
    endcase
  end

  // Result word assembly
  assign res_x_w   = 16'(res_x);
  assign res_y_w   = 16'(res_y);
  assign res_cnt_w = 32'(res_cnt);
  assign max_w     = 32'(max_nxt);
  assign len_w     = 32'(count_nxt);

  always_comb begin
    out_data_nxt.accepted       = res_acc;
    out_data_nxt.cell_x         = res_x_w[7:0];
    out_data_nxt.cell_y         = res_y_w[7:0];
    out_data_nxt.cell_count     = res_cnt_w[15:0];
    out_data_nxt.cell_color     = res_col;
    out_data_nxt.cell_transform = res_tid;
    out_data_nxt.max_count      = max_w[15:0];
    out_data_nxt.list_length    = len_w[16:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phacc_pkg::BK_IDLE;
      count_r     <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      max_r   <= max_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      cmd_r <= pop_cmd;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Memory ports, registered read
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    if (list_re) begin
      list_q <= list_mem[list_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CMPW'(NUM_CELLS))
    else $error("touched list length beyond grid size");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready && pop_cmd.kind == phacc_pkg::CMD_CLEAR)
      |=> (count_r == '0 && max_r == '0))
    else $error("clear did not reset length and max");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + CMPW'(1)
         || count_r == '0))
    else $error("list length moved by more than one");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != phacc_pkg::BK_IDLE) |-> !pop_ready)
    else $error("command popped while busy");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phacc_pkg::BK_ADD_FIN || state_r == phacc_pkg::BK_RD_FIN) |-> slot_free)
    else $error("result register occupied at finish");

endmodule

// File: design/pixel_hit_accumulator.sv
// Pixel hit accumulator top: grid size registers, front classifier, command queue, back end.
// Add and valid read: two dependent registered memory reads, then write back or result once the
// result register is free. Clear, miss and bad read load the result register at accept.
// Back end is busy until an add or read ends; front accepts one word per cycle until the queue fills.
// Reset (synchronous, rst_n low) empties queue and result register, zeroes list length and max
// registers; grid sizes reset to 256. No memory clearing pass: clear only zeroes length and max.
module pixel_hit_accumulator #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int COUNT_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  phacc_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output phacc_pkg::out_item_t  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [8:0]        grid_width_r, grid_height_r;
  logic              cfg_write;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  phacc_pkg::cmd_t   push_cmd, pop_cmd;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= phacc_pkg::GRID_SIZE_RESET;
      grid_height_r <= phacc_pkg::GRID_SIZE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        phacc_pkg::REG_GRID_WIDTH:  grid_width_r  <= pwdata[8:0];
        phacc_pkg::REG_GRID_HEIGHT: grid_height_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      phacc_pkg::REG_GRID_WIDTH:  prdata = {23'd0, grid_width_r};
      phacc_pkg::REG_GRID_HEIGHT: prdata = {23'd0, grid_height_r};
      default:                    prdata = '0;
    endcase
  end

  phacc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  phacc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  phacc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
